### design/bbsf_pkg.sv
// ----------------------------------------------------------------------------
// bbsf_pkg
// Shared constants, types and helpers of the bounded byte stream FIFO.
// ----------------------------------------------------------------------------
package bbsf_pkg;

    // Storage depth of the byte ring.
    localparam int DEPTH   = 4096;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;

    // Fixed widths of the interface fields.
    localparam int OP_W    = 3;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 13;
    localparam int CAP_W   = 13;
    localparam int TOTAL_W = 64;
    localparam int CMP_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
    localparam logic [OP_W-1:0] OP_READ  = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP   = 3'd3;
    localparam logic [OP_W-1:0] OP_END   = 3'd4;

    // Configuration register indexes.
    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic                 accepted;
        logic [BYTE_W-1:0]    out_byte;
        logic [COUNT_W-1:0]   buffered;
        logic [COUNT_W-1:0]   room_left;
        logic                 ended;
        logic                 at_eof;
        logic [TOTAL_W-1:0]   total_written;
        logic [TOTAL_W-1:0]   total_read;
    } result_t;

    // Position in the ring that lies off bytes past base. The offset never
    // exceeds the depth where the result is used, so one subtract wraps it.
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

### design/bbsf_ram.sv
// ----------------------------------------------------------------------------
// bbsf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bbsf_ram #(
    parameter int DEPTH_P = 4096,
    parameter int WIDTH_P = 8
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH_P)-1:0] waddr,
    input  logic [WIDTH_P-1:0]         wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH_P)-1:0] raddr,
    output logic [WIDTH_P-1:0]         rdata
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];
    logic [WIDTH_P-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/bbsf_cfg.sv
// ----------------------------------------------------------------------------
// bbsf_cfg
// APB register port holding the capacity register.
// ----------------------------------------------------------------------------
module bbsf_cfg
    import bbsf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [CAP_W-1:0]  capacity
);

    logic [CAP_W-1:0] capacity_reg;
    logic             wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (wr_en && (paddr[2] == REG_CAPACITY))
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_CAPACITY: prdata = 32'(capacity_reg);
            default:      prdata = '0;
        endcase
    end

    assign capacity = capacity_reg;

endmodule

### design/bbsf_core.sv
// ----------------------------------------------------------------------------
// bbsf_core
// Ring pointer state, operation decode and the byte store access stage.
// ----------------------------------------------------------------------------
module bbsf_core
    import bbsf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     op,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic [COUNT_W-1:0]  count,
    input  logic [CAP_W-1:0]    capacity,
    input  logic                s1_ready,
    output logic                s1_valid,
    output result_t             s1
);

    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               closed_reg, closed_next;
    logic [TOTAL_W-1:0] wtotal_reg, wtotal_next;
    logic [TOTAL_W-1:0] rtotal_reg, rtotal_next;
    logic               s1_valid_reg;
    result_t            s1_reg;
    logic               s1_from_mem_reg;

    logic               take;
    logic [CNT_W-1:0]   cap_eff;
    logic [CMP_W-1:0]   count_w;
    logic [CMP_W-1:0]   fill_w;
    logic [CNT_W-1:0]   pop_n;
    logic               acc;
    logic               mem_we;
    logic               mem_re;
    logic [PTR_W-1:0]   mem_raddr;
    logic [PTR_W-1:0]   tail;
    logic [BYTE_W-1:0]  mem_rdata;
    logic [CNT_W-1:0]   room;

    // The stage can take a new word unless its current word is stuck.
    assign in_stall = s1_valid_reg && !s1_ready;
    assign take     = in_valid && !in_stall;

    assign cap_eff = (CMP_W'(capacity) > CMP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(capacity);
    assign count_w = CMP_W'(count);
    assign fill_w  = CMP_W'(fill_reg);
    assign pop_n   = (count_w < fill_w) ? CNT_W'(count) : fill_reg;
    assign tail    = ring_add(head_reg, fill_reg);

    always_comb
    begin
        head_next   = head_reg;
        fill_next   = fill_reg;
        closed_next = closed_reg;
        wtotal_next = wtotal_reg;
        rtotal_next = rtotal_reg;
        acc         = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = head_reg;
        case (op)
            OP_WRITE:
            begin
                if (!closed_reg && (fill_reg < cap_eff))
                begin
                    mem_we      = take;
                    fill_next   = fill_reg + 1'b1;
                    wtotal_next = wtotal_reg + 1'b1;
                    acc         = 1'b1;
                end
            end
            OP_READ:
            begin
                if (fill_reg != '0)
                begin
                    mem_re      = take;
                    head_next   = ring_add(head_reg, CNT_W'(1));
                    fill_next   = fill_reg - 1'b1;
                    rtotal_next = rtotal_reg + 1'b1;
                    acc         = 1'b1;
                end
            end
            OP_PEEK:
            begin
                mem_raddr = ring_add(head_reg, CNT_W'(count));
                if (count_w < fill_w)
                begin
                    mem_re = take;
                    acc    = 1'b1;
                end
            end
            OP_POP:
            begin
                head_next   = ring_add(head_reg, pop_n);
                fill_next   = fill_reg - pop_n;
                rtotal_next = rtotal_reg + TOTAL_W'(pop_n);
            end
            OP_END:
            begin
                closed_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign room = (fill_next < cap_eff) ? (cap_eff - fill_next) : '0;

    bbsf_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (BYTE_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (tail),
        .wdata (data_byte),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            fill_reg     <= '0;
            closed_reg   <= 1'b0;
            wtotal_reg   <= '0;
            rtotal_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            head_reg     <= head_next;
            fill_reg     <= fill_next;
            closed_reg   <= closed_next;
            wtotal_reg   <= wtotal_next;
            rtotal_reg   <= rtotal_next;
            s1_valid_reg <= 1'b1;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Status of the word in flight; its byte is loaded into the RAM read register on the same edge.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_reg.accepted      <= acc;
            s1_reg.out_byte      <= '0;
            s1_reg.buffered      <= COUNT_W'(fill_next);
            s1_reg.room_left     <= COUNT_W'(room);
            s1_reg.ended         <= closed_next;
            s1_reg.at_eof        <= closed_next && (fill_next == '0);
            s1_reg.total_written <= wtotal_next;
            s1_reg.total_read    <= rtotal_next;
            s1_from_mem_reg      <= mem_re;
        end
    end

    always_comb
    begin
        s1 = s1_reg;
        if (s1_from_mem_reg)
        begin
            s1.out_byte = mem_rdata;
        end
    end

    assign s1_valid = s1_valid_reg;

endmodule

### design/bounded_byte_stream_fifo_top.sv
// Two register stages, the access stage and the output register; a result
// can wait in either of them while the output stalls.
// Throughput: one word per cycle unless the output stalls; the byte store
// has one write and one read port, so every operation issues at most one
// RAM access. The output register frees the input side while a result waits.
// Reset is asynchronous: pointers, fill, totals and flags clear, capacity
// returns to 4096; the byte store itself is not cleared.
// ----------------------------------------------------------------------------
// bounded_byte_stream_fifo_top
// Byte FIFO with configurable capacity and an end-of-input mark.
// ----------------------------------------------------------------------------
module bounded_byte_stream_fifo_top
    import bbsf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     op,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic [COUNT_W-1:0]  count,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                accepted,
    output logic [BYTE_W-1:0]   out_byte,
    output logic [COUNT_W-1:0]  buffered,
    output logic [COUNT_W-1:0]  room_left,
    output logic                ended,
    output logic                at_eof,
    output logic [TOTAL_W-1:0]  total_written,
    output logic [TOTAL_W-1:0]  total_read
);

    logic [CAP_W-1:0] capacity;
    logic             s1_ready;
    logic             s1_valid;
    result_t          s1;
    logic             out_valid_reg;
    result_t          out_reg;

    bbsf_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    bbsf_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .data_byte (data_byte),
        .count     (count),
        .capacity  (capacity),
        .s1_ready  (s1_ready),
        .s1_valid  (s1_valid),
        .s1        (s1)
    );

    assign s1_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            out_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s1_valid)
        begin
            out_reg <= s1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = out_reg.accepted;
    assign out_byte      = out_reg.out_byte;
    assign buffered      = out_reg.buffered;
    assign room_left     = out_reg.room_left;
    assign ended         = out_reg.ended;
    assign at_eof        = out_reg.at_eof;
    assign total_written = out_reg.total_written;
    assign total_read    = out_reg.total_read;

    // End of file is only ever reported with an empty buffer after end of input.
    a_eof_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!at_eof || (ended && (buffered == '0))))
        else $error("at_eof reported with data held or input open");

    // Held bytes plus free room never exceed the store depth.
    a_room_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((CNT_W + 1)'(buffered) + (CNT_W + 1)'(room_left)
                       <= (CNT_W + 1)'(DEPTH)))
        else $error("buffered plus room_left exceeds depth");

    // A word left in the access stage while the output is blocked must stay there.
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && !s1_ready) |=> s1_valid)
        else $error("access stage word lost while output stalled");

    // A refused or status-only word never carries a byte.
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !accepted) |-> (out_byte == '0))
        else $error("nonzero byte on a result that was not accepted");

endmodule
